FILE: rtl/bzr_pkg.sv
// Shared constants and types for the cubic Bezier point and tangent core.
`timescale 1ns / 1ps
`default_nettype none

package bzr_pkg;

    localparam int STAGES = 5;

    localparam int CRD_W  = 16;
    localparam int CTRL_W = 3 * CRD_W;
    localparam int T_W    = 17;
    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    localparam int SQ_W  = 33;
    localparam int WP_W  = 49;
    localparam int WT_W  = 34;
    localparam int DIF_W = CRD_W + 1;

    localparam int PP_W  = WP_W + CRD_W;
    localparam int ACC_W = 64;
    localparam int POS_FRAC = 48;

    localparam int TP_W   = WT_W + 1 + DIF_W;
    localparam int TACC_W = TP_W + 2;
    localparam int TAN_FRAC = 32;
    localparam int TQ_W   = TACC_W - TAN_FRAC;
    localparam int TAN_W  = 19;

    typedef struct packed {
        logic [STAGES-1:0] load;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [WP_W-1:0] w0;
        logic [WP_W-1:0] w1;
        logic [WP_W-1:0] w2;
        logic [WP_W-1:0] w3;
        logic [WT_W-1:0] d0;
        logic [WT_W-1:0] d1;
        logic [WT_W-1:0] d2;
    } weights_t;

endpackage

`default_nettype wire

FILE: rtl/bzr_in_if.sv
// Input channel: four packed control points and the curve parameter.
`timescale 1ns / 1ps
`default_nettype none

interface bzr_in_if;
    logic                        valid;
    logic                        ready;
    logic [bzr_pkg::CTRL_W-1:0]  ctrl_a;
    logic [bzr_pkg::CTRL_W-1:0]  ctrl_b;
    logic [bzr_pkg::CTRL_W-1:0]  ctrl_c;
    logic [bzr_pkg::CTRL_W-1:0]  ctrl_d;
    logic [bzr_pkg::T_W-1:0]     param_t;

    modport source (
        output valid,
        output ctrl_a,
        output ctrl_b,
        output ctrl_c,
        output ctrl_d,
        output param_t,
        input  ready
    );

    modport sink (
        input  valid,
        input  ctrl_a,
        input  ctrl_b,
        input  ctrl_c,
        input  ctrl_d,
        input  param_t,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/bzr_out_if.sv
// Output channel: curve point and tangent on three axes.
`timescale 1ns / 1ps
`default_nettype none

interface bzr_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [bzr_pkg::CRD_W-1:0]   pos_x;
    logic signed [bzr_pkg::CRD_W-1:0]   pos_y;
    logic signed [bzr_pkg::CRD_W-1:0]   pos_z;
    logic signed [bzr_pkg::TAN_W-1:0]   tan_x;
    logic signed [bzr_pkg::TAN_W-1:0]   tan_y;
    logic signed [bzr_pkg::TAN_W-1:0]   tan_z;

    modport source (
        output valid,
        output pos_x,
        output pos_y,
        output pos_z,
        output tan_x,
        output tan_y,
        output tan_z,
        input  ready
    );

    modport sink (
        input  valid,
        input  pos_x,
        input  pos_y,
        input  pos_z,
        input  tan_x,
        input  tan_y,
        input  tan_z,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/bzr_axis.sv
// Per-axis datapath: weighted sums of the control coordinates, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none

module bzr_axis (
    input  wire logic                                clk,
    input  wire bzr_pkg::pipe_ctrl_t                 ctrl,
    input  wire logic [bzr_pkg::CRD_W-1:0]           crd_a,
    input  wire logic [bzr_pkg::CRD_W-1:0]           crd_b,
    input  wire logic [bzr_pkg::CRD_W-1:0]           crd_c,
    input  wire logic [bzr_pkg::CRD_W-1:0]           crd_d,
    input  wire bzr_pkg::weights_t                   wts,
    output logic signed [bzr_pkg::CRD_W-1:0]         pos,
    output logic signed [bzr_pkg::TAN_W-1:0]         tan
);

    localparam logic [bzr_pkg::CRD_W-1:0] SIGN_FLIP = {1'b1, {(bzr_pkg::CRD_W-1){1'b0}}};
    localparam logic [bzr_pkg::ACC_W-1:0] POS_HALF  =
        {{(bzr_pkg::ACC_W-bzr_pkg::POS_FRAC){1'b0}}, 1'b1, {(bzr_pkg::POS_FRAC-1){1'b0}}};
    localparam logic [bzr_pkg::TACC_W-1:0] TAN_HALF =
        {{(bzr_pkg::TACC_W-bzr_pkg::TAN_FRAC){1'b0}}, 1'b1, {(bzr_pkg::TAN_FRAC-1){1'b0}}};

    logic [bzr_pkg::CRD_W-1:0]          off1_reg [4];
    logic [bzr_pkg::CRD_W-1:0]          off2_reg [4];
    logic [bzr_pkg::CRD_W-1:0]          off3_reg [4];
    logic signed [bzr_pkg::DIF_W-1:0]   dif1_reg [3];
    logic signed [bzr_pkg::DIF_W-1:0]   dif2_reg [3];
    logic signed [bzr_pkg::DIF_W-1:0]   dif3_reg [3];
    logic [bzr_pkg::ACC_W-1:0]          pp_reg [4];
    logic signed [bzr_pkg::TP_W-1:0]    tp_reg [3];
    logic signed [bzr_pkg::CRD_W-1:0]   pos_reg;
    logic signed [bzr_pkg::TAN_W-1:0]   tan_reg;

    logic signed [bzr_pkg::DIF_W-1:0]   sa;
    logic signed [bzr_pkg::DIF_W-1:0]   sb;
    logic signed [bzr_pkg::DIF_W-1:0]   sc;
    logic signed [bzr_pkg::DIF_W-1:0]   sd;
    logic [bzr_pkg::PP_W-1:0]           pprod [4];
    logic signed [bzr_pkg::TP_W-1:0]    tprod [3];
    logic [bzr_pkg::WP_W-1:0]           wsel [4];
    logic [bzr_pkg::WT_W-1:0]           dsel [3];
    logic [bzr_pkg::ACC_W-1:0]          acc;
    logic signed [bzr_pkg::TACC_W-1:0]  tacc;
    logic [bzr_pkg::CRD_W-1:0]          rnd;
    logic signed [bzr_pkg::TQ_W-1:0]    q;
    logic signed [bzr_pkg::CRD_W-1:0]   pos_next;
    logic signed [bzr_pkg::TAN_W-1:0]   tan_next;

    assign sa = $signed({crd_a[bzr_pkg::CRD_W-1], crd_a});
    assign sb = $signed({crd_b[bzr_pkg::CRD_W-1], crd_b});
    assign sc = $signed({crd_c[bzr_pkg::CRD_W-1], crd_c});
    assign sd = $signed({crd_d[bzr_pkg::CRD_W-1], crd_d});

    assign wsel[0] = wts.w0;
    assign wsel[1] = wts.w1;
    assign wsel[2] = wts.w2;
    assign wsel[3] = wts.w3;
    assign dsel[0] = wts.d0;
    assign dsel[1] = wts.d1;
    assign dsel[2] = wts.d2;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pprod[i] = wsel[i] * off3_reg[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            tprod[i] = $signed({1'b0, dsel[i]}) * dif3_reg[i];
        end
    end

    // The offset coordinates keep the point sum unsigned; flipping the top bit
    // of the rounded sum removes the offset again.
    always_comb
    begin
        acc = pp_reg[0] + pp_reg[1] + pp_reg[2] + pp_reg[3] + POS_HALF;
        rnd = acc[bzr_pkg::ACC_W-1 -: bzr_pkg::CRD_W];
        pos_next = $signed(rnd ^ SIGN_FLIP);

        tacc = {{2{tp_reg[0][bzr_pkg::TP_W-1]}}, tp_reg[0]}
             + {{2{tp_reg[1][bzr_pkg::TP_W-1]}}, tp_reg[1]}
             + {{2{tp_reg[2][bzr_pkg::TP_W-1]}}, tp_reg[2]}
             + $signed(TAN_HALF);
        q = tacc[bzr_pkg::TACC_W-1 -: bzr_pkg::TQ_W];
        if (q[bzr_pkg::TQ_W-1:bzr_pkg::TAN_W-1] == {(bzr_pkg::TQ_W-bzr_pkg::TAN_W+1){1'b0}} ||
            q[bzr_pkg::TQ_W-1:bzr_pkg::TAN_W-1] == {(bzr_pkg::TQ_W-bzr_pkg::TAN_W+1){1'b1}})
        begin
            tan_next = q[bzr_pkg::TAN_W-1:0];
        end
        else
        begin
            tan_next = {q[bzr_pkg::TQ_W-1], {(bzr_pkg::TAN_W-1){~q[bzr_pkg::TQ_W-1]}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            off1_reg[0] <= crd_a ^ SIGN_FLIP;
            off1_reg[1] <= crd_b ^ SIGN_FLIP;
            off1_reg[2] <= crd_c ^ SIGN_FLIP;
            off1_reg[3] <= crd_d ^ SIGN_FLIP;
            dif1_reg[0] <= sb - sa;
            dif1_reg[1] <= sc - sb;
            dif1_reg[2] <= sd - sc;
        end
        if (ctrl.load[1])
        begin
            off2_reg <= off1_reg;
            dif2_reg <= dif1_reg;
        end
        if (ctrl.load[2])
        begin
            off3_reg <= off2_reg;
            dif3_reg <= dif2_reg;
        end
        if (ctrl.load[3])
        begin
            for (int i = 0; i < 4; i++)
            begin
                pp_reg[i] <= pprod[i][bzr_pkg::ACC_W-1:0];
            end
            tp_reg <= tprod;
        end
        if (ctrl.load[4])
        begin
            pos_reg <= pos_next;
            tan_reg <= tan_next;
        end
    end

    assign pos = pos_reg;
    assign tan = tan_reg;

endmodule

`default_nettype wire

FILE: rtl/cubic_bezier_point_and_tangent_core.sv
// Top level of the cubic Bezier point and tangent core with its five-stage pipeline.
// Usage:
//   The req channel takes one word per cycle as long as rsp.ready is high: four
//   control points packed as x, y, z in signed Q8.8 and the parameter t in
//   unsigned Q1.16, where values above 65536 count as 1.0. The rsp channel
//   returns one word for each input word, in order: the curve point in signed
//   Q8.8 and the derivative with respect to t in signed Q11.8 on 19 bits.
//   Throughput is one word per cycle while rsp.ready is high; the 33 by 17
//   bit weight products and the 49 by 16 bit point products each own a stage,
//   and the final stage adds, rounds and saturates. Every stage carries a
//   valid bit and loads whenever it is empty or the stage after it moves on,
//   so bubbles close up while the receiver stalls and req.ready falls only
//   once all five stages hold words.
//   Reset clears all valid bits; the pipeline is empty and ready afterward.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_point_and_tangent_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    bzr_in_if.sink       req,
    bzr_out_if.source    rsp
);

    localparam int S = bzr_pkg::STAGES;

    logic [S-1:0]                  valid_reg;
    logic [S-1:0]                  valid_next;
    logic [S:0]                    rdy;
    bzr_pkg::pipe_ctrl_t           ctrl;

    logic [bzr_pkg::T_W-1:0]       t_clamp;
    logic [bzr_pkg::T_W-1:0]       s1_t_reg;
    logic [bzr_pkg::T_W-1:0]       s1_u_reg;
    logic [bzr_pkg::T_W-1:0]       s2_t_reg;
    logic [bzr_pkg::T_W-1:0]       s2_u_reg;
    logic [bzr_pkg::SQ_W-1:0]      s2_uu_reg;
    logic [bzr_pkg::SQ_W-1:0]      s2_tt_reg;
    logic [bzr_pkg::SQ_W-1:0]      s2_ut_reg;
    logic [2*bzr_pkg::T_W-1:0]     m_uu;
    logic [2*bzr_pkg::T_W-1:0]     m_tt;
    logic [2*bzr_pkg::T_W-1:0]     m_ut;

    logic [bzr_pkg::SQ_W+bzr_pkg::T_W-1:0]  m_uuu;
    logic [bzr_pkg::SQ_W+bzr_pkg::T_W-1:0]  m_uut;
    logic [bzr_pkg::SQ_W+bzr_pkg::T_W-1:0]  m_ttu;
    logic [bzr_pkg::SQ_W+bzr_pkg::T_W-1:0]  m_ttt;
    logic [bzr_pkg::SQ_W+bzr_pkg::T_W+1:0]  x_uut;
    logic [bzr_pkg::SQ_W+bzr_pkg::T_W+1:0]  x_ttu;
    logic [bzr_pkg::SQ_W+2:0]               x_uu;
    logic [bzr_pkg::SQ_W+2:0]               x_tt;
    logic [bzr_pkg::SQ_W+2:0]               x_ut;
    bzr_pkg::weights_t                      wts_next;
    bzr_pkg::weights_t                      s3_wts_reg;

    always_comb
    begin
        rdy[S] = rsp.ready;
        for (int k = S - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (rdy[0])
        begin
            valid_next[0] = req.valid;
        end
        for (int k = 1; k < S; k++)
        begin
            if (rdy[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load = rdy[S-1:0];
    assign req.ready = rdy[0];
    assign rsp.valid = valid_reg[S-1];

    assign t_clamp = (req.param_t > bzr_pkg::T_ONE) ? bzr_pkg::T_ONE : req.param_t;

    assign m_uu = s1_u_reg * s1_u_reg;
    assign m_tt = s1_t_reg * s1_t_reg;
    assign m_ut = s1_u_reg * s1_t_reg;

    // Point weights are Q1.48 and tangent weights Q2.32; the factors of three
    // and six are shift-and-add terms on the registered squares and their products.
    always_comb
    begin
        m_uuu = s2_uu_reg * s2_u_reg;
        m_uut = s2_uu_reg * s2_t_reg;
        m_ttu = s2_tt_reg * s2_u_reg;
        m_ttt = s2_tt_reg * s2_t_reg;
        x_uut = {2'b00, m_uut} + {1'b0, m_uut, 1'b0};
        x_ttu = {2'b00, m_ttu} + {1'b0, m_ttu, 1'b0};
        x_uu  = {3'b000, s2_uu_reg} + {2'b00, s2_uu_reg, 1'b0};
        x_tt  = {3'b000, s2_tt_reg} + {2'b00, s2_tt_reg, 1'b0};
        x_ut  = {2'b00, s2_ut_reg, 1'b0} + {1'b0, s2_ut_reg, 2'b00};

        wts_next.w0 = m_uuu[bzr_pkg::WP_W-1:0];
        wts_next.w1 = x_uut[bzr_pkg::WP_W-1:0];
        wts_next.w2 = x_ttu[bzr_pkg::WP_W-1:0];
        wts_next.w3 = m_ttt[bzr_pkg::WP_W-1:0];
        wts_next.d0 = x_uu[bzr_pkg::WT_W-1:0];
        wts_next.d1 = x_ut[bzr_pkg::WT_W-1:0];
        wts_next.d2 = x_tt[bzr_pkg::WT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            s1_t_reg <= t_clamp;
            s1_u_reg <= bzr_pkg::T_ONE - t_clamp;
        end
        if (ctrl.load[1])
        begin
            s2_t_reg  <= s1_t_reg;
            s2_u_reg  <= s1_u_reg;
            s2_uu_reg <= m_uu[bzr_pkg::SQ_W-1:0];
            s2_tt_reg <= m_tt[bzr_pkg::SQ_W-1:0];
            s2_ut_reg <= m_ut[bzr_pkg::SQ_W-1:0];
        end
        if (ctrl.load[2])
        begin
            s3_wts_reg <= wts_next;
        end
    end

    bzr_axis u_axis_x (
        .clk   (clk),
        .ctrl  (ctrl),
        .crd_a (req.ctrl_a[3*bzr_pkg::CRD_W-1 -: bzr_pkg::CRD_W]),
        .crd_b (req.ctrl_b[3*bzr_pkg::CRD_W-1 -: bzr_pkg::CRD_W]),
        .crd_c (req.ctrl_c[3*bzr_pkg::CRD_W-1 -: bzr_pkg::CRD_W]),
        .crd_d (req.ctrl_d[3*bzr_pkg::CRD_W-1 -: bzr_pkg::CRD_W]),
        .wts   (s3_wts_reg),
        .pos   (rsp.pos_x),
        .tan   (rsp.tan_x)
    );

    bzr_axis u_axis_y (
        .clk   (clk),
        .ctrl  (ctrl),
        .crd_a (req.ctrl_a[2*bzr_pkg::CRD_W-1 -: bzr_pkg::CRD_W]),
        .crd_b (req.ctrl_b[2*bzr_pkg::CRD_W-1 -: bzr_pkg::CRD_W]),
        .crd_c (req.ctrl_c[2*bzr_pkg::CRD_W-1 -: bzr_pkg::CRD_W]),
        .crd_d (req.ctrl_d[2*bzr_pkg::CRD_W-1 -: bzr_pkg::CRD_W]),
        .wts   (s3_wts_reg),
        .pos   (rsp.pos_y),
        .tan   (rsp.tan_y)
    );

    bzr_axis u_axis_z (
        .clk   (clk),
        .ctrl  (ctrl),
        .crd_a (req.ctrl_a[bzr_pkg::CRD_W-1:0]),
        .crd_b (req.ctrl_b[bzr_pkg::CRD_W-1:0]),
        .crd_c (req.ctrl_c[bzr_pkg::CRD_W-1:0]),
        .crd_d (req.ctrl_d[bzr_pkg::CRD_W-1:0]),
        .wts   (s3_wts_reg),
        .pos   (rsp.pos_z),
        .tan   (rsp.tan_z)
    );

endmodule

`default_nettype wire

FILE: rtl/bzr_checker.sv
// Port-level checks on the core's handshakes and pipeline occupancy, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bzr_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_ready,
    input  wire logic out_valid,
    input  wire logic out_ready
);

    localparam int OCC_W = $clog2(bzr_pkg::STAGES + 1) + 1;
    localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(bzr_pkg::STAGES);

    logic              in_take;
    logic              out_take;
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    always_comb
    begin
        occ_next = occ_reg;
        if (in_take && !out_take)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (!in_take && out_take)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // A waiting result word stays until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // With the last stage empty the whole pipeline can advance.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output stage");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_MAX)
        else $error("more words in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != '0)
        else $error("result word shown with no word in flight");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == OCC_MAX && !out_ready |-> !in_ready)
        else $error("input accepted into a full stalled pipeline");

endmodule

bind cubic_bezier_point_and_tangent_core bzr_checker u_bzr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready)
);

`default_nettype wire
